// File: rtl/lpfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpfp_pkg: shared types and constants of the length-prefixed frame parser
// Header layout, result codes, register indexes and the queue entry format.
// ----------------------------------------------------------------------------
package lpfp_pkg;

   // Header: 2 bytes message id, 4 bytes body length, 8 bytes send time (LE)
   localparam int HEADER_BYTES = 14;
   localparam int HDR_CNT_W    = 4;
   localparam int BODY_REM_W   = 17;
   localparam int IDLE_W       = 16;
   localparam int LEN_W        = 32;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_TIMEOUT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_BODY_LEN = 2'd1;

   localparam logic [IDLE_W-1:0]     TIMEOUT_RESET  = 16'd1500;
   localparam logic [BODY_REM_W-1:0] MAX_BODY_RESET = 17'd65536;

   // Input word mode
   localparam logic MODE_DATA = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_BODY   = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   // Parser phase
   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_BODY    = 3'b010,
      PH_DISCARD = 3'b100
   } phase_type;

   // One result word waiting between front and back
   typedef struct packed {
      kind_type                    kind;
      logic [7:0]                  body_byte;
      logic                        last_of_frame;
      logic [HEADER_BYTES*8-1:0]   header;
   } q_entry_type;

endpackage

`default_nettype wire

// File: rtl/length_prefixed_frame_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser_unit: length-prefixed frame deframer
// Splits a byte stream into 14-byte headers and bodies, one result per
// header, body byte or length error; millisecond ticks drive an idle timeout.
//
//   channel   dir   handshake              payload
//   req       in    req_valid/req_ready    req_mode, req_data_byte
//   rsp       out   rsp_valid/rsp_ready    rsp_kind .. rsp_last_of_frame
//   csr       in    csr_valid/csr_ready    csr_index, csr_wdata
//
// One word per cycle while the queue has space; a byte's result is pushed
// at the edge that takes it and reaches the output register once that is free.
// req_ready drops only when the result queue (QUEUE_DEPTH words) is full.
// csr_ready is always high. Synchronous reset: idle timeout 1500 ms, body
// limit 65536, parser in header phase.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_mode,
   input  wire logic [7:0]                       req_data_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [1:0]                            rsp_kind,
   output logic [15:0]                           rsp_msg_id,
   output logic [31:0]                           rsp_body_len,
   output logic [63:0]                           rsp_send_time,
   output logic [7:0]                            rsp_body_byte,
   output logic                                  rsp_last_of_frame,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [lpfp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [lpfp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic                  q_space;
   logic                  push_valid;
   lpfp_pkg::q_entry_type push_entry;
   logic                  head_valid;
   lpfp_pkg::q_entry_type head_entry;
   logic                  pop;

   lpfp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_data_byte (req_data_byte),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .q_space       (q_space),
      .push_valid    (push_valid),
      .push_entry    (push_entry)
   );

   lpfp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .space      (q_space),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   lpfp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_entry        (head_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_msg_id        (rsp_msg_id),
      .rsp_body_len      (rsp_body_len),
      .rsp_send_time     (rsp_send_time),
      .rsp_body_byte     (rsp_body_byte),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

`default_nettype wire

// File: rtl/lpfp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpfp_front: input side of the frame parser
// Accepts bytes and ticks, tracks the frame phase, collects the header and
// pushes one result word per header, body byte or length error.
// ----------------------------------------------------------------------------
module lpfp_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input words
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_mode,
   input  wire logic [7:0]                           req_data_byte,
   // configuration writes
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [lpfp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [lpfp_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // result queue
   input  wire logic                                 q_space,
   output logic                                      push_valid,
   output lpfp_pkg::q_entry_type                     push_entry
);

   localparam logic [lpfp_pkg::HDR_CNT_W-1:0] LAST_IDX =
      lpfp_pkg::HDR_CNT_W'(lpfp_pkg::HEADER_BYTES - 1);
   localparam logic [lpfp_pkg::HDR_CNT_W-1:0] HDR_FULL =
      lpfp_pkg::HDR_CNT_W'(lpfp_pkg::HEADER_BYTES);

   // configuration registers
   logic [lpfp_pkg::IDLE_W-1:0]     timeout_ff;
   logic [lpfp_pkg::BODY_REM_W-1:0] max_len_ff;

   // parser state
   lpfp_pkg::phase_type             phase_ff, phase_in;
   logic [lpfp_pkg::HDR_CNT_W-1:0]  count_ff, count_in;
   logic [lpfp_pkg::BODY_REM_W-1:0] rem_ff, rem_in;
   logic [lpfp_pkg::IDLE_W-1:0]     idle_ff, idle_in;
   logic [7:0]                      hdr_ff [lpfp_pkg::HEADER_BYTES];

   logic                            accept;
   logic                            is_byte;
   logic                            is_tick;
   logic                            timed_out;
   lpfp_pkg::phase_type             eff_phase;
   logic [lpfp_pkg::HDR_CNT_W-1:0]  eff_count;
   logic [lpfp_pkg::HDR_CNT_W-1:0]  hdr_idx;
   logic                            hdr_we;
   logic [lpfp_pkg::LEN_W-1:0]      len_view;
   lpfp_pkg::kind_type              kind;
   logic                            last;
   logic [7:0]                      out_byte;

   assign req_ready = q_space;
   assign csr_ready = 1'b1;

   assign accept  = req_valid & req_ready;
   assign is_byte = accept & (req_mode == lpfp_pkg::MODE_DATA);
   assign is_tick = accept & (req_mode == lpfp_pkg::MODE_TICK);

   // idle timeout restarts the frame before the byte is looked at
   assign timed_out = idle_ff > timeout_ff;
   assign eff_phase = timed_out ? lpfp_pkg::PH_HEADER : phase_ff;
   assign eff_count = timed_out ? '0 : count_ff;
   assign hdr_idx   = (eff_count >= HDR_FULL) ? '0 : eff_count;
   assign len_view  = {hdr_ff[5], hdr_ff[4], hdr_ff[3], hdr_ff[2]};

   // next state and result classification
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      rem_in     = rem_ff;
      idle_in    = idle_ff;
      hdr_we     = 1'b0;
      push_valid = 1'b0;
      kind       = lpfp_pkg::KIND_BODY;
      last       = 1'b0;
      out_byte   = 8'd0;

      if (is_tick) begin
         if (idle_ff != '1) begin
            idle_in = idle_ff + 1'b1;
         end
      end else if (is_byte) begin
         idle_in  = '0;
         phase_in = eff_phase;
         count_in = eff_count;
         if (eff_phase == lpfp_pkg::PH_DISCARD) begin
            // dropped until the next timeout
         end else if (eff_phase == lpfp_pkg::PH_BODY && rem_ff != '0) begin
            rem_in     = rem_ff - 1'b1;
            push_valid = 1'b1;
            kind       = lpfp_pkg::KIND_BODY;
            out_byte   = req_data_byte;
            if (rem_ff == lpfp_pkg::BODY_REM_W'(1)) begin
               phase_in = lpfp_pkg::PH_HEADER;
               count_in = '0;
               last     = 1'b1;
            end
         end else begin
            // header collection
            phase_in = lpfp_pkg::PH_HEADER;
            hdr_we   = 1'b1;
            if (hdr_idx == LAST_IDX) begin
               count_in   = '0;
               push_valid = 1'b1;
               if (len_view > {{(lpfp_pkg::LEN_W - lpfp_pkg::BODY_REM_W){1'b0}},
                               max_len_ff}) begin
                  phase_in = lpfp_pkg::PH_DISCARD;
                  rem_in   = '0;
                  kind     = lpfp_pkg::KIND_ERROR;
               end else if (len_view == '0) begin
                  rem_in = '0;
                  kind   = lpfp_pkg::KIND_HEADER;
                  last   = 1'b1;
               end else begin
                  phase_in = lpfp_pkg::PH_BODY;
                  rem_in   = len_view[lpfp_pkg::BODY_REM_W-1:0];
                  kind     = lpfp_pkg::KIND_HEADER;
               end
            end else begin
               count_in = hdr_idx + 1'b1;
            end
         end
      end
   end

   // result word, with the byte being written bypassed into the header view
   always_comb begin
      push_entry.kind          = kind;
      push_entry.body_byte     = out_byte;
      push_entry.last_of_frame = last;
      for (int i = 0; i < lpfp_pkg::HEADER_BYTES; i++) begin
         push_entry.header[i*8 +: 8] =
            (hdr_we && hdr_idx == lpfp_pkg::HDR_CNT_W'(i)) ? req_data_byte : hdr_ff[i];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= lpfp_pkg::PH_HEADER;
         count_ff   <= '0;
         rem_ff     <= '0;
         idle_ff    <= '0;
         timeout_ff <= lpfp_pkg::TIMEOUT_RESET;
         max_len_ff <= lpfp_pkg::MAX_BODY_RESET;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         rem_ff   <= rem_in;
         idle_ff  <= idle_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == lpfp_pkg::CSR_IDLE_TIMEOUT) begin
               timeout_ff <= csr_wdata[lpfp_pkg::IDLE_W-1:0];
            end else if (csr_index == lpfp_pkg::CSR_MAX_BODY_LEN) begin
               max_len_ff <= csr_wdata[lpfp_pkg::BODY_REM_W-1:0];
            end
         end
      end
   end

   // header byte store
   always_ff @(posedge clock) begin
      if (hdr_we) begin
         hdr_ff[hdr_idx] <= req_data_byte;
      end
   end

`ifndef SYNTHESIS
   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (req_valid && req_ready && req_mode == lpfp_pkg::MODE_DATA))
      else $error("result pushed without an accepted data byte");

   // a timeout may leave a stale count behind in header phase
   a_body_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == lpfp_pkg::PH_BODY) |-> (rem_ff != '0))
      else $error("body phase with no bytes remaining");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < HDR_FULL)
      else $error("header count out of range");
`endif

endmodule

`default_nettype wire

// File: rtl/lpfp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpfp_queue: result queue between parser front and output stage
// Small circular buffer of result words; lets each side stall on its own.
// ----------------------------------------------------------------------------
module lpfp_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   input  wire lpfp_pkg::q_entry_type push_entry,
   output logic                       space,
   output logic                       head_valid,
   output lpfp_pkg::q_entry_type      head_entry,
   input  wire logic                  pop
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   lpfp_pkg::q_entry_type buf_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   assign space      = count_ff != CNT_FULL;
   assign head_valid = count_ff != '0;
   assign head_entry = buf_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (push_valid) begin
         buf_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty result queue");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid && !pop |-> count_ff != CNT_FULL)
      else $error("push into full result queue");
`endif

endmodule

`default_nettype wire

// File: rtl/lpfp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpfp_back: output stage of the frame parser
// Takes words from the queue, unpacks the header fields and holds the
// result in a register until the consumer takes it.
// ----------------------------------------------------------------------------
module lpfp_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  head_valid,
   input  wire lpfp_pkg::q_entry_type head_entry,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [1:0]                 rsp_kind,
   output logic [15:0]                rsp_msg_id,
   output logic [31:0]                rsp_body_len,
   output logic [63:0]                rsp_send_time,
   output logic [7:0]                 rsp_body_byte,
   output logic                       rsp_last_of_frame
);

   logic        valid_ff;
   logic [1:0]  kind_ff;
   logic [15:0] msg_id_ff;
   logic [31:0] body_len_ff;
   logic [63:0] send_time_ff;
   logic [7:0]  body_byte_ff;
   logic        last_ff;

   // load whenever the output register is empty or being taken
   assign pop = head_valid && (!valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   // little-endian field unpack
   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff      <= head_entry.kind;
         msg_id_ff    <= head_entry.header[15:0];
         body_len_ff  <= head_entry.header[47:16];
         send_time_ff <= head_entry.header[111:48];
         body_byte_ff <= head_entry.body_byte;
         last_ff      <= head_entry.last_of_frame;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_msg_id        = msg_id_ff;
   assign rsp_body_len      = body_len_ff;
   assign rsp_send_time     = send_time_ff;
   assign rsp_body_byte     = body_byte_ff;
   assign rsp_last_of_frame = last_ff;

endmodule

`default_nettype wire
